// ===== rtl/ctss_pkg.sv =====
// Shared types and constants of the countdown timer with seven-segment display.
`timescale 1ns / 1ps

package ctss_pkg;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned MIN_W = 7;
	localparam int unsigned SEC_W = 6;
	localparam int unsigned SEG_W = 7;
	localparam int unsigned DIG_W = 4;
	localparam int unsigned IDX_W = 2;

	// register indexes on the write port
	localparam logic [IDX_W-1:0] REG_TICK_PER_SECOND = 2'd0;
	localparam logic [IDX_W-1:0] REG_BUZZER_TICKS    = 2'd1;
	localparam logic [IDX_W-1:0] REG_BLINK_TICKS     = 2'd2;

	localparam logic [CFG_W-1:0] TICK_PER_SECOND_RST = 16'd1000;
	localparam logic [CFG_W-1:0] BUZZER_TICKS_RST    = 16'd300;
	localparam logic [CFG_W-1:0] BLINK_TICKS_RST     = 16'd500;

	localparam logic [MIN_W-1:0] MINUTE_MAX = 7'd99;
	localparam logic [SEC_W-1:0] SECOND_MAX = 6'd59;

	// active-high segment patterns for digits 0..9, bit0 a to bit6 g
	localparam logic [SEG_W-1:0] SEG_CODE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

	typedef struct packed {
		logic tick;
		logic enc_clock;
		logic enc_data;
		logic button_level;
	} in_item_t;

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [DIG_W-1:0] digit_enable;
		logic             buzzer;
		logic             colon;
		logic [MIN_W-1:0] minutes_now;
		logic [SEC_W-1:0] seconds_now;
		logic             running_now;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] tick_per_second;
		logic [CFG_W-1:0] buzzer_ticks;
		logic [CFG_W-1:0] blink_ticks;
	} cfg_t;

	typedef struct packed {
		logic [MIN_W-1:0] minutes;
		logic [SEC_W-1:0] seconds;
	} clock_time_t;

	typedef struct packed {
		logic [MIN_W-1:0] minutes;
		logic [SEC_W-1:0] seconds;
		logic             running;
		logic [1:0]       digit_index;
		logic [CFG_W-1:0] second_count;
		logic [CFG_W-1:0] buzz_count;
		logic [CFG_W-1:0] blink_count;
		logic [SEG_W-1:0] shown_segments;
		logic [DIG_W-1:0] shown_digit;
		logic             buzz_on;
		logic             colon_on;
		logic             last_clock;
		logic             last_button;
	} state_t;

	localparam state_t STATE_RST = '{
		minutes: '0, seconds: '0, running: 1'b0, digit_index: '0,
		second_count: '0, buzz_count: '0, blink_count: '0,
		shown_segments: '0, shown_digit: '0, buzz_on: 1'b0, colon_on: 1'b0,
		last_clock: 1'b0, last_button: 1'b1
	};

endpackage

// ===== rtl/ctss_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps

interface ctss_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/countdown_timer_seven_segment.sv =====
// Top level of the countdown timer with multiplexed seven-segment display.
// Each accepted beat is captured in the input register, and its result is then loaded into
// the result register once that register is free or being drained, where it is offered.
// Throughput: one beat per cycle while the sink keeps taking results; ctss_step is a single pass.
// Reset (arst_n low, asynchronous): time 00:00, stopped, display blank, button
// seen released, registers at 1000 / 300 / 500 ticks, both stages empty.
`timescale 1ns / 1ps

module countdown_timer_seven_segment (
	input  logic                          clk,
	input  logic                          arst_n,
	ctss_stream_if.sink                   item,
	ctss_stream_if.source                 result,
	input  logic                          wr_en,
	input  logic [ctss_pkg::IDX_W-1:0]    wr_index,
	input  logic [ctss_pkg::CFG_W-1:0]    wr_data
);

	ctss_pkg::cfg_t      cfg_q;
	ctss_pkg::state_t    state_q;
	ctss_pkg::state_t    state_d;
	ctss_pkg::in_item_t  item_s1;
	logic                item_valid_s1;
	ctss_pkg::out_item_t result_s2;
	logic                result_valid_s2;
	logic                advance;

	// Configuration writes: the user must write only while idle; the block does not
	// enforce it. A write simply overwrites; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_per_second <= ctss_pkg::TICK_PER_SECOND_RST;
			cfg_q.buzzer_ticks    <= ctss_pkg::BUZZER_TICKS_RST;
			cfg_q.blink_ticks     <= ctss_pkg::BLINK_TICKS_RST;
		end else if (wr_en) begin
			case (wr_index)
				ctss_pkg::REG_TICK_PER_SECOND: cfg_q.tick_per_second <= wr_data;
				ctss_pkg::REG_BUZZER_TICKS:    cfg_q.buzzer_ticks    <= wr_data;
				ctss_pkg::REG_BLINK_TICKS:     cfg_q.blink_ticks     <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// The stage-1 beat moves on whenever the result register is free or being
	// drained this cycle. The input side is open whenever stage 1 empties, so
	// one waiting result does not stop the next beat from being taken; with
	// both stages full and the sink holding off, the input stalls.
	assign advance    = item_valid_s1 && (!result_valid_s2 || result.ready);
	assign item.ready = !item_valid_s1 || advance;

	// Input register: capture the raw pin samples and tick flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// One pass over edges, display step, countdown, buzzer and colon.
	ctss_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (state_d)
	);

	// Timer state advances exactly once per beat, as it leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctss_pkg::STATE_RST;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register: hold until the sink takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.segments     <= state_d.shown_segments;
			result_s2.digit_enable <= state_d.shown_digit;
			result_s2.buzzer       <= state_d.buzz_on;
			result_s2.colon        <= state_d.colon_on;
			result_s2.minutes_now  <= state_d.minutes;
			result_s2.seconds_now  <= state_d.seconds;
			result_s2.running_now  <= state_d.running;
		end
	end

	assign result.valid = result_valid_s2;
	assign result.data  = result_s2;

	// A beat leaving stage 1 always shows up as a pending result.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_s2)
	else $error("stage-1 beat lost on its way to the result register");

	// The buzzer only sounds while its count has ticks left.
	a_buzz_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.buzz_on |-> (state_q.buzz_count != '0))
	else $error("buzzer on with an empty buzz count");

	// Time stays within 00:00 .. 99:59.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.minutes <= ctss_pkg::MINUTE_MAX) && (state_q.seconds <= ctss_pkg::SECOND_MAX))
	else $error("time out of range");

	// At most one digit is enabled in any offered result.
	a_digit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 |-> $onehot0(result_s2.digit_enable))
	else $error("more than one digit enabled");

endmodule

// ===== rtl/ctss_digit.sv =====
// Digit select and active-low seven-segment decode for the multiplexed display.
`timescale 1ns / 1ps

module ctss_digit (
	input  logic [ctss_pkg::MIN_W-1:0] minutes,
	input  logic [ctss_pkg::SEC_W-1:0] seconds,
	input  logic [1:0]                 digit_index,
	output logic [ctss_pkg::SEG_W-1:0] segments
);

	logic [6:0]  value;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  ones;
	logic [3:0]  digit;

	// pick minutes for the two left digits, seconds for the right two
	assign value = digit_index[1] ? {1'b0, seconds} : minutes;

	// divide by ten as multiply by 205 and shift by 11, exact below 180
	assign prod = {8'd0, value} * 15'd205;
	assign tens = prod[14:11];
	assign ones = value - 7'({3'd0, tens} * 7'd10);

	assign digit = digit_index[0] ? ones[3:0] : tens;

	always_comb begin
		case (digit)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
				segments = ~ctss_pkg::SEG_CODE[digit];
			end
			default: begin
				segments = ctss_pkg::SEG_BLANK;
			end
		endcase
	end

endmodule

// ===== rtl/ctss_step.sv =====
// Next-state logic of the timer for one input beat.
`timescale 1ns / 1ps

module ctss_step (
	input  ctss_pkg::state_t   cur,
	input  ctss_pkg::in_item_t item,
	input  ctss_pkg::cfg_t     cfg,
	output ctss_pkg::state_t   nxt
);

	function automatic ctss_pkg::clock_time_t add_second(ctss_pkg::clock_time_t t);
		ctss_pkg::clock_time_t r;
		r = t;
		if (t.seconds == ctss_pkg::SECOND_MAX) begin
			r.seconds = '0;
			r.minutes = (t.minutes == ctss_pkg::MINUTE_MAX) ? '0 : t.minutes + 7'd1;
		end else begin
			r.seconds = t.seconds + 6'd1;
		end
		return r;
	endfunction

	function automatic ctss_pkg::clock_time_t remove_second(ctss_pkg::clock_time_t t);
		ctss_pkg::clock_time_t r;
		r = t;
		if (t.seconds == '0) begin
			if (t.minutes != '0) begin
				r.minutes = t.minutes - 7'd1;
				r.seconds = ctss_pkg::SECOND_MAX;
			end
		end else begin
			r.seconds = t.seconds - 6'd1;
		end
		return r;
	endfunction

	ctss_pkg::clock_time_t                  set_time;
	logic                                   set_running;
	logic [ctss_pkg::SEG_W-1:0]             segs;
	logic [ctss_pkg::CFG_W:0]               sec_sum;
	logic [ctss_pkg::CFG_W-1:0]             buzz_load;
	ctss_pkg::clock_time_t                  down_time;

	// encoder and button edges come first
	always_comb begin
		set_time    = '{minutes: cur.minutes, seconds: cur.seconds};
		set_running = cur.running;
		if (item.enc_clock && !cur.last_clock) begin
			set_time = item.enc_data ? remove_second(set_time) : add_second(set_time);
		end
		if (!item.button_level && cur.last_button) begin
			set_running = ~cur.running;
		end
	end

	ctss_digit u_digit (
		.minutes     (set_time.minutes),
		.seconds     (set_time.seconds),
		.digit_index (cur.digit_index),
		.segments    (segs)
	);

	assign sec_sum   = {1'b0, cur.second_count} + 17'd1;
	assign down_time = remove_second(set_time);

	always_comb begin
		nxt             = cur;
		nxt.minutes     = set_time.minutes;
		nxt.seconds     = set_time.seconds;
		nxt.running     = set_running;
		nxt.last_clock  = item.enc_clock;
		nxt.last_button = item.button_level;
		buzz_load       = cur.buzz_count;
		if (item.tick) begin
			nxt.shown_segments = segs;
			nxt.shown_digit    = 4'b0001 << cur.digit_index;
			nxt.digit_index    = cur.digit_index + 2'd1;

			if (sec_sum >= {1'b0, cfg.tick_per_second}) begin
				nxt.second_count = '0;
				if (set_running) begin
					nxt.minutes = down_time.minutes;
					nxt.seconds = down_time.seconds;
					if (down_time.minutes == '0 && down_time.seconds == '0) begin
						nxt.running = 1'b0;
						buzz_load   = cfg.buzzer_ticks;
						if (cfg.buzzer_ticks != '0) begin
							nxt.buzz_on = 1'b1;
						end
					end
				end
			end else begin
				nxt.second_count = sec_sum[ctss_pkg::CFG_W-1:0];
			end

			nxt.buzz_count = buzz_load;
			if (buzz_load != '0) begin
				nxt.buzz_count = buzz_load - 16'd1;
				if (buzz_load == 16'd1) begin
					nxt.buzz_on = 1'b0;
				end
			end

			nxt.blink_count = cur.blink_count + 16'd1;
			if (nxt.running) begin
				if (nxt.blink_count >= cfg.blink_ticks) begin
					nxt.colon_on    = ~cur.colon_on;
					nxt.blink_count = '0;
				end
			end else begin
				nxt.colon_on = 1'b1;
			end
		end
	end

endmodule

// ===== tb/sv/countdown_timer_seven_segment_test.sv =====
// Self-checking testbench of the countdown timer with multiplexed seven-segment display.
`timescale 1ns / 1ps

module countdown_timer_seven_segment_test;

	// one row of the directed table; want is meaningful only where typed is set
	typedef struct packed {
		logic                typed;
		ctss_pkg::in_item_t  beat;
		ctss_pkg::out_item_t want;
	} stim_row_t;

	// active-high glyphs of digits 0..9, bit0 a to bit6 g
	localparam logic [ctss_pkg::SEG_W-1:0] DIGIT_GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	// nothing latched yet: display blank, 00:00, stopped
	localparam ctss_pkg::out_item_t BLANK_FRAME = '0;
	// first tick after reset: tens of minutes shows 0, colon lit while stopped
	localparam ctss_pkg::out_item_t TENS_ZERO_FRAME = '{
		segments: 7'h40, digit_enable: 4'b0001, buzzer: 1'b0, colon: 1'b1,
		minutes_now: '0, seconds_now: '0, running_now: 1'b0
	};

	localparam int DIRECTED_ROWS = 25;
	// fields of each beat: tick, enc_clock, enc_data, button_level
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b1, 4'b0001, BLANK_FRAME},      // idle pins right after reset
		'{1'b1, 4'b1001, TENS_ZERO_FRAME},  // first tick latches digit 0
		'{1'b1, 4'b0111, TENS_ZERO_FRAME},  // remove a second at 00:00: hold at zero
		'{1'b0, 4'b0011, '0},
		'{1'b0, 4'b0101, '0},               // add a second
		'{1'b0, 4'b0001, '0},
		'{1'b0, 4'b0101, '0},
		'{1'b0, 4'b1001, '0},
		'{1'b0, 4'b0111, '0},               // remove a second
		'{1'b0, 4'b0000, '0},               // press: start
		'{1'b0, 4'b1000, '0},               // held: no second toggle
		'{1'b0, 4'b0001, '0},               // release
		'{1'b0, 4'b1001, '0},
		'{1'b0, 4'b1001, '0},
		'{1'b0, 4'b1100, '0},               // add, press and tick in one beat
		'{1'b0, 4'b1011, '0},
		'{1'b0, 4'b0000, '0},
		'{1'b0, 4'b1001, '0},
		'{1'b0, 4'b1111, '0},               // remove while running
		'{1'b0, 4'b1011, '0},
		'{1'b0, 4'b1110, '0},               // remove and stop in one beat
		'{1'b0, 4'b1001, '0},
		'{1'b0, 4'b1101, '0},
		'{1'b0, 4'b1011, '0},
		'{1'b0, 4'b1110, '0}
	};

	localparam int PHASES = 7;

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [ctss_pkg::IDX_W-1:0]     wr_index;
	logic [ctss_pkg::CFG_W-1:0]     wr_data;

	ctss_stream_if #(.T(ctss_pkg::in_item_t))  item_ch ();
	ctss_stream_if #(.T(ctss_pkg::out_item_t)) result_ch ();

	countdown_timer_seven_segment u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// shadow of the timer and of its registers, advanced once per accepted beat
	ctss_pkg::state_t    tmr;
	ctss_pkg::cfg_t      regs;
	ctss_pkg::out_item_t frames_due [$];

	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_left;

	// pin levels last offered, so random traffic forms real detents and presses
	logic        pin_clk;
	logic        pin_dat;
	logic        pin_btn;

	ctss_pkg::cfg_t phase_cfg [PHASES];
	int             phase_items [PHASES];
	int             phase_up_pct [PHASES];

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Remove one second; stop at 00:00, borrow a minute at :00.
	function automatic void step_down();
		if (tmr.seconds == '0) begin
			if (tmr.minutes != '0) begin
				tmr.minutes = tmr.minutes - 1'b1;
				tmr.seconds = ctss_pkg::SECOND_MAX;
			end
		end else begin
			tmr.seconds = tmr.seconds - 1'b1;
		end
	endfunction

	// Apply one beat to the shadow timer and return the frame it must produce.
	function automatic ctss_pkg::out_item_t advance_timer(input ctss_pkg::in_item_t beat);
		ctss_pkg::out_item_t frame;
		int unsigned         digit;

		// encoder detent on the rising clock pin, direction from the data pin
		if (beat.enc_clock && !tmr.last_clock) begin
			if (beat.enc_data) begin
				step_down();
			end else if (tmr.seconds == ctss_pkg::SECOND_MAX) begin
				tmr.seconds = '0;
				tmr.minutes = (tmr.minutes == ctss_pkg::MINUTE_MAX) ? '0 : tmr.minutes + 1'b1;
			end else begin
				tmr.seconds = tmr.seconds + 1'b1;
			end
		end
		tmr.last_clock = beat.enc_clock;

		// falling button level toggles start/stop
		if (!beat.button_level && tmr.last_button)
			tmr.running = ~tmr.running;
		tmr.last_button = beat.button_level;

		if (beat.tick) begin
			// latch the current digit, tens of minutes first
			case (tmr.digit_index)
				2'd0: digit = tmr.minutes / 10;
				2'd1: digit = tmr.minutes % 10;
				2'd2: digit = tmr.seconds / 10;
				default: digit = tmr.seconds % 10;
			endcase
			tmr.shown_segments = ~DIGIT_GLYPH[digit];
			tmr.shown_digit = 4'b0001 << tmr.digit_index;
			tmr.digit_index = tmr.digit_index + 1'b1;

			// compare with >= so a lowered limit fires at once, and zero acts as one
			if (32'(tmr.second_count) + 1 >= 32'(regs.tick_per_second)) begin
				tmr.second_count = '0;
				if (tmr.running) begin
					step_down();
					if (tmr.minutes == '0 && tmr.seconds == '0) begin
						tmr.running = 1'b0;
						tmr.buzz_count = regs.buzzer_ticks;
						if (regs.buzzer_ticks != '0)
							tmr.buzz_on = 1'b1;
					end
				end
			end else begin
				tmr.second_count = tmr.second_count + 1'b1;
			end

			// buzzer count is loaded and decremented on the same tick
			if (tmr.buzz_count != '0) begin
				tmr.buzz_count = tmr.buzz_count - 1'b1;
				if (tmr.buzz_count == '0)
					tmr.buzz_on = 1'b0;
			end

			// blink counter runs (and wraps) even while stopped; colon forced on then
			tmr.blink_count = tmr.blink_count + 1'b1;
			if (tmr.running) begin
				if (tmr.blink_count >= regs.blink_ticks) begin
					tmr.colon_on = ~tmr.colon_on;
					tmr.blink_count = '0;
				end
			end else begin
				tmr.colon_on = 1'b1;
			end
		end

		frame.segments     = tmr.shown_segments;
		frame.digit_enable = tmr.shown_digit;
		frame.buzzer       = tmr.buzz_on;
		frame.colon        = tmr.colon_on;
		frame.minutes_now  = tmr.minutes;
		frame.seconds_now  = tmr.seconds;
		frame.running_now  = tmr.running;
		return frame;
	endfunction

	// Build one random beat: mostly ticks with detents and presses, some raw noise.
	function automatic ctss_pkg::in_item_t next_random_beat(input int tick_pct,
			input int up_pct, input int btn_pct);
		ctss_pkg::in_item_t beat;

		if ($urandom_range(99) < 6) begin
			beat = ctss_pkg::in_item_t'(4'($urandom));
			pin_clk = beat.enc_clock;
			pin_dat = beat.enc_data;
			pin_btn = beat.button_level;
			return beat;
		end
		beat.tick = ($urandom_range(99) < tick_pct);
		if ($urandom_range(99) < 20) begin
			pin_clk = ~pin_clk;
			if (pin_clk)
				pin_dat = ($urandom_range(99) >= up_pct);
		end else if ($urandom_range(99) < 10) begin
			pin_dat = 1'($urandom_range(1));
		end
		if ($urandom_range(99) < btn_pct)
			pin_btn = ~pin_btn;
		beat.enc_clock    = pin_clk;
		beat.enc_data     = pin_dat;
		beat.button_level = pin_btn;
		return beat;
	endfunction

	// Offer one beat after a random gap, hold it until accepted, then book its frame.
	task automatic send_beat(input ctss_pkg::in_item_t beat, input logic typed,
			input ctss_pkg::out_item_t want);
		ctss_pkg::out_item_t predicted;

		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= beat;
		do @(posedge clk); while (!item_ch.ready);
		predicted = advance_timer(beat);
		frames_due.push_back(typed ? want : predicted);
	endtask

	// Drop valid and wait until every booked frame has come back.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
	endtask

	// Write all three registers back to back; only called while the block is idle.
	task automatic program_regs(input ctss_pkg::cfg_t c);
		wr_en    <= 1'b1;
		wr_index <= ctss_pkg::REG_TICK_PER_SECOND;
		wr_data  <= c.tick_per_second;
		@(posedge clk);
		regs.tick_per_second = c.tick_per_second;
		wr_index <= ctss_pkg::REG_BUZZER_TICKS;
		wr_data  <= c.buzzer_ticks;
		@(posedge clk);
		regs.buzzer_ticks = c.buzzer_ticks;
		wr_index <= ctss_pkg::REG_BLINK_TICKS;
		wr_data  <= c.blink_ticks;
		@(posedge clk);
		regs.blink_ticks = c.blink_ticks;
		wr_en <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: check each accepted frame against the oldest booked one, then
	// decide ready for the next edge; a hold-off forces ready low for a stretch.
	always @(posedge clk) begin
		ctss_pkg::out_item_t want;
		ctss_pkg::out_item_t got;

		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (frames_due.size() == 0) begin
				$display("%0t ns: unexpected frame: expected none, actual %h", $time, got);
				mismatches++;
			end else begin
				want = frames_due.pop_front();
				check_field("segments", want.segments, got.segments);
				check_field("digit_enable", want.digit_enable, got.digit_enable);
				check_field("buzzer", want.buzzer, got.buzzer);
				check_field("colon", want.colon, got.colon);
				check_field("minutes_now", want.minutes_now, got.minutes_now);
				check_field("seconds_now", want.seconds_now, got.seconds_now);
				check_field("running_now", want.running_now, got.running_now);
			end
		end
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Give up long after the slowest legal run would have finished.
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		// drive every input to a known level from time zero
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = '0;
		wr_data         = '0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		mismatches      = 0;
		hold_left       = 0;
		send_idle_pct   = 36;
		recv_idle_pct   = 48;
		tmr             = ctss_pkg::STATE_RST;
		regs            = '{tick_per_second: 16'd1000, buzzer_ticks: 16'd300,
			blink_ticks: 16'd500};
		pin_clk         = 1'b0;
		pin_dat         = 1'b0;
		pin_btn         = 1'b1;

		// Phase 0 keeps the reset registers; later phases sweep extremes, zero
		// limits and random small values.
		phase_cfg[0] = regs;
		phase_cfg[1] = '{tick_per_second: 16'd1, buzzer_ticks: 16'd1, blink_ticks: 16'd1};
		phase_cfg[2] = '{tick_per_second: 16'd3, buzzer_ticks: 16'd5, blink_ticks: 16'd2};
		phase_cfg[3] = '{tick_per_second: 16'hFFFF, buzzer_ticks: 16'hFFFF,
			blink_ticks: 16'hFFFF};
		phase_cfg[4] = '{tick_per_second: 16'd1, buzzer_ticks: 16'd0, blink_ticks: 16'd7};
		phase_cfg[5] = '{tick_per_second: 16'd0, buzzer_ticks: 16'd2, blink_ticks: 16'hFFFF};
		phase_cfg[6] = '{tick_per_second: 16'($urandom_range(6, 1)),
			buzzer_ticks: 16'($urandom_range(20, 1)), blink_ticks: 16'($urandom_range(10, 1))};
		phase_items  = '{300, 80, 80, 80, 80, 80, 80};
		phase_up_pct = '{75, 70, 65, 60, 50, 65, 60};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table first, reset registers in place
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
		settle();
		pin_clk = DIRECTED[DIRECTED_ROWS-1].beat.enc_clock;
		pin_dat = DIRECTED[DIRECTED_ROWS-1].beat.enc_data;
		pin_btn = DIRECTED[DIRECTED_ROWS-1].beat.button_level;

		for (int p = 0; p < PHASES; p++) begin
			// receiver-heavy idling first, then sender-heavy, then none
			if (p < 3) begin
				send_idle_pct = 36;
				recv_idle_pct = 48;
			end else if (p < 5) begin
				send_idle_pct = 48;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p != 0)
				program_regs(phase_cfg[p]);

			for (int i = 0; i < phase_items[p]; i++) begin
				// pause the sender until the pipe is empty, then resume
				if (p == 1 && i == 65)
					settle();
				// starve the output while beats keep coming, so the input stalls
				if (p == 2 && i == 40)
					hold_left = 400;
				send_beat(next_random_beat(p == 0 ? 90 : 60, phase_up_pct[p],
					p == 0 ? 1 : 5), 1'b0, '0);
			end
			settle();
		end

		// let any stray frame show up before the verdict
		repeat (8) @(posedge clk);
		if (mismatches == 0 && frames_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== countdown_timer_seven_segment.f =====
rtl/ctss_pkg.sv
rtl/ctss_stream_if.sv
rtl/ctss_digit.sv
rtl/ctss_step.sv
rtl/countdown_timer_seven_segment.sv
tb/sv/countdown_timer_seven_segment_test.sv
